// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, disabled while reset is asserted.
`define RBSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// A stalled beat keeps its payload until it is taken.
`define RBSI_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(data))) \
    else $error("%m: stalled beat changed");

`endif

// File: hw/rtl/rbsi_pkg.sv
// Package with types, constants and the divider step of the ray/box slab test.
package rbsi_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned DIR_FRAC   = 14;
  localparam int unsigned NUM_W      = 48;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;
  // Prep stage, divider stages, lane result, merge, output register.
  localparam int unsigned NUM_STAGES = DIV_STAGES + 4;
  localparam int unsigned IN_W       = 144;
  localparam int unsigned OUT_W      = 72;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_st_t;

  // Several restoring division steps; the remainder stays below the divisor.
  function automatic div_st_t div_steps(div_st_t s_in, logic [DEN_W-1:0] den);
    div_st_t s;
    logic [DEN_W:0] trial;
    s = s_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {s.rem, s.num[NUM_W-1]};
      s.num = {s.num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        s.rem = trial[DEN_W-1:0];
        s.quo = {s.quo[NUM_W-2:0], 1'b1};
      end else begin
        s.rem = trial[DEN_W-1:0];
        s.quo = {s.quo[NUM_W-2:0], 1'b0};
      end
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/rbsi_div.sv
// Pipelined unsigned divider, a few quotient bits per stage, with sign tag.
module rbsi_div (
  input  logic                            clk_i,
  input  logic [rbsi_pkg::DIV_STAGES-1:0] en_i,
  input  logic [rbsi_pkg::NUM_W-1:0]      num_i,
  input  logic [rbsi_pkg::DEN_W-1:0]      den_i,
  input  logic                            neg_i,
  output logic [rbsi_pkg::NUM_W-1:0]      quo_o,
  output logic                            neg_o
);
  import rbsi_pkg::*;

  div_st_t          st_q  [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic             neg_q [DIV_STAGES];
  div_st_t          st_d  [DIV_STAGES];

  always_comb begin
    st_d[0] = div_steps('{rem: '0, num: num_i, quo: '0}, den_i);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_d[s] = div_steps(st_q[s-1], den_q[s-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_q[0]  <= st_d[0];
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en_i[s]) begin
        st_q[s]  <= st_d[s];
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule

// File: hw/rtl/rbsi_lane.sv
// One axis: plane distances through two dividers, saturation and ordering.
module rbsi_lane (
  input  logic                                clk_i,
  input  logic [rbsi_pkg::DIV_STAGES+1:0]     en_i,
  input  logic signed [rbsi_pkg::COORD_W-1:0] bmin_i,
  input  logic signed [rbsi_pkg::COORD_W-1:0] bmax_i,
  input  logic signed [rbsi_pkg::COORD_W-1:0] org_i,
  input  logic signed [rbsi_pkg::DIR_W-1:0]   dir_i,
  output logic signed [rbsi_pkg::COORD_W-1:0] entry_o,
  output logic signed [rbsi_pkg::COORD_W-1:0] exit_o
);
  import rbsi_pkg::*;

  logic signed [COORD_W:0]   diff_a, diff_b;
  logic [COORD_W:0]          mag_a, mag_b;
  logic [DEN_W-1:0]          den_d;
  logic signed [COORD_W-1:0] lo, hi;
  logic                      inside_d;

  logic [NUM_W-1:0] num_a_q, num_b_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_a_q, neg_b_q;
  logic             dz_q    [DIV_STAGES+1];
  logic             inside_q[DIV_STAGES+1];

  logic [NUM_W-1:0]          quo_a, quo_b;
  logic                      qneg_a, qneg_b;
  logic signed [COORD_W-1:0] ta, tb;
  logic signed [COORD_W-1:0] entry_d, exit_d;
  logic signed [COORD_W-1:0] entry_q, exit_q;

  function automatic logic signed [COORD_W-1:0] sat(logic [NUM_W-1:0] mag, logic neg);
    logic signed [COORD_W-1:0] r;
    if (neg) begin
      if (mag > {{(NUM_W-COORD_W){1'b0}}, T_MIN}) r = T_MIN;
      else r = ~mag[COORD_W-1:0] + 1'b1;
    end else begin
      if (mag > {{(NUM_W-COORD_W){1'b0}}, T_MAX}) r = T_MAX;
      else r = mag[COORD_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    diff_a   = {bmin_i[COORD_W-1], bmin_i} - {org_i[COORD_W-1], org_i};
    diff_b   = {bmax_i[COORD_W-1], bmax_i} - {org_i[COORD_W-1], org_i};
    mag_a    = diff_a[COORD_W] ? (~diff_a + 1'b1) : diff_a;
    mag_b    = diff_b[COORD_W] ? (~diff_b + 1'b1) : diff_b;
    den_d    = dir_i[DIR_W-1] ? (~dir_i + 1'b1) : dir_i;
    lo       = (bmin_i < bmax_i) ? bmin_i : bmax_i;
    hi       = (bmin_i < bmax_i) ? bmax_i : bmin_i;
    inside_d = (org_i >= lo) && (org_i <= hi);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_a_q     <= {1'b0, mag_a, {DIR_FRAC{1'b0}}};
      num_b_q     <= {1'b0, mag_b, {DIR_FRAC{1'b0}}};
      den_q       <= den_d;
      neg_a_q     <= diff_a[COORD_W] ^ dir_i[DIR_W-1];
      neg_b_q     <= diff_b[COORD_W] ^ dir_i[DIR_W-1];
      dz_q[0]     <= (dir_i == '0);
      inside_q[0] <= inside_d;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      if (en_i[s]) begin
        dz_q[s]     <= dz_q[s-1];
        inside_q[s] <= inside_q[s-1];
      end
    end
    if (en_i[DIV_STAGES+1]) begin
      entry_q <= entry_d;
      exit_q  <= exit_d;
    end
  end

  rbsi_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_STAGES:1]),
    .num_i (num_a_q),
    .den_i (den_q),
    .neg_i (neg_a_q),
    .quo_o (quo_a),
    .neg_o (qneg_a)
  );

  rbsi_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en_i[DIV_STAGES:1]),
    .num_i (num_b_q),
    .den_i (den_q),
    .neg_i (neg_b_q),
    .quo_o (quo_b),
    .neg_o (qneg_b)
  );

  always_comb begin
    ta = sat(quo_a, qneg_a);
    tb = sat(quo_b, qneg_b);
    if (dz_q[DIV_STAGES]) begin
      // A flat direction either leaves the axis open or rules the ray out.
      entry_d = inside_q[DIV_STAGES] ? T_MIN : T_MAX;
      exit_d  = inside_q[DIV_STAGES] ? T_MAX : T_MIN;
    end else begin
      entry_d = (ta < tb) ? ta : tb;
      exit_d  = (ta < tb) ? tb : ta;
    end
  end

  assign entry_o = entry_q;
  assign exit_o  = exit_q;

endmodule

// File: hw/rtl/rbsi_merge.sv
// Merge of the three axes: largest entry, smallest exit, then the hit flag.
module rbsi_merge (
  input  logic                                clk_i,
  input  logic [1:0]                          en_i,
  input  logic signed [rbsi_pkg::COORD_W-1:0] entry_i [rbsi_pkg::NUM_AXES],
  input  logic signed [rbsi_pkg::COORD_W-1:0] exit_i  [rbsi_pkg::NUM_AXES],
  output logic                                hit_o,
  output logic signed [rbsi_pkg::COORD_W-1:0] t_near_o,
  output logic signed [rbsi_pkg::COORD_W-1:0] t_far_o
);
  import rbsi_pkg::*;

  logic signed [COORD_W-1:0] near_d, far_d, near_q, far_q;
  logic signed [COORD_W-1:0] t_near_q, t_far_q;
  logic                      hit_q;

  always_comb begin
    near_d = T_MIN;
    far_d  = T_MAX;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (entry_i[a] > near_d) near_d = entry_i[a];
      if (exit_i[a] < far_d) far_d = exit_i[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      near_q <= near_d;
      far_q  <= far_d;
    end
    if (en_i[1]) begin
      t_near_q <= near_q;
      t_far_q  <= far_q;
      hit_q    <= (far_q > near_q);
    end
  end

  assign hit_o    = hit_q;
  assign t_near_o = t_near_q;
  assign t_far_o  = t_far_q;

endmodule

// File: hw/rtl/ray_box_slab_intersection.sv
// Top level of the ray/box slab test: registers, stage control, lanes, merge.
//
//  channel  direction  beat                     fields (low bit first)
//  s_axis   in         one ray                  origin x/y/z, dir x/y/z
//  m_axis   out        one result per ray       hit, t_near, t_far
//  cfg      in         one register write       box corners
//
// One ray enters per cycle unless a stalled output backs the pipeline up.
// Most stages lie in the 12-stage dividers, four quotient bits each.
// Reset clears the box registers and all stage valid flags.
// A stalled output holds its stage; earlier stages keep moving into bubbles.
module ray_box_slab_intersection (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rbsi_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit, t_near, t_far, zero fill
  output logic [rbsi_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbsi_pkg::COORD_W-1:0]    cfg_wdata_i
);
  import rbsi_pkg::*;

  logic signed [COORD_W-1:0] box_min_q [NUM_AXES];
  logic signed [COORD_W-1:0] box_max_q [NUM_AXES];
  logic [NUM_STAGES-1:0]     vld_q, vld_d, en;
  logic signed [COORD_W-1:0] org  [NUM_AXES];
  logic signed [DIR_W-1:0]   dir  [NUM_AXES];
  logic signed [COORD_W-1:0] entry[NUM_AXES];
  logic signed [COORD_W-1:0] exitd[NUM_AXES];
  logic                      hit;
  logic signed [COORD_W-1:0] t_near, t_far;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_MIN_X: box_min_q[0] <= cfg_wdata_i;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_wdata_i;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int s = 1; s < NUM_STAGES; s++) begin
      vld_d[s] = en[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= vld_d;
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      org[a] = s_axis_tdata[a*COORD_W +: COORD_W];
      dir[a] = s_axis_tdata[NUM_AXES*COORD_W + a*DIR_W +: DIR_W];
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en[DIV_STAGES+1:0]),
      .bmin_i  (box_min_q[a]),
      .bmax_i  (box_max_q[a]),
      .org_i   (org[a]),
      .dir_i   (dir[a]),
      .entry_o (entry[a]),
      .exit_o  (exitd[a])
    );
  end

  rbsi_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en[NUM_STAGES-1:NUM_STAGES-2]),
    .entry_i  (entry),
    .exit_i   (exitd),
    .hit_o    (hit),
    .t_near_o (t_near),
    .t_far_o  (t_far)
  );

  assign m_axis_tdata = {{(OUT_W - 2*COORD_W - 1){1'b0}}, t_far, t_near, hit};

endmodule

// File: hw/rtl/rbsi_checker.sv
// Port-level checker of the ray/box slab test, bound to the top level.
`include "assert_macros.svh"

module rbsi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rbsi_pkg::OUT_W-1:0]     m_axis_tdata
);
  import rbsi_pkg::*;

  // When the output side can move, the whole pipeline can take a ray.
  `RBSI_ASSERT(a_ready_free, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)

  // The hit flag agrees with the two distances it came from.
  `RBSI_ASSERT(a_hit_order, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[0] == ($signed(m_axis_tdata[64:33]) > $signed(m_axis_tdata[32:1]))))

  `RBSI_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)

endmodule

bind ray_box_slab_intersection rbsi_checker u_rbsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
